@@ hw/rtl/dtfr_pkg.sv @@
package dtfr_pkg;

    localparam int FRAME_WIDTH_DEF = 128;
    localparam int PAGE_COUNT_DEF  = 8;
    localparam int COUNT_W         = 11;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 11'd2047;
    localparam logic [COUNT_W-1:0] THRESH_RESET = 11'd32;
    localparam logic [1:0] OFFSET_RESET = 2'd2;

    // Command codes.
    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_PULL  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_ACK  = 3'd0;
    localparam logic [2:0] KIND_POS  = 3'd1;
    localparam logic [2:0] KIND_DATA = 3'd2;
    localparam logic [2:0] KIND_DONE = 3'd3;
    localparam logic [2:0] KIND_BUSY = 3'd4;

    // Configuration register indexes.
    localparam logic [0:0] REG_THRESH = 1'd0;
    localparam logic [0:0] REG_OFFSET = 1'd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_on;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  page;
        logic [7:0]  ram_column;
        logic [7:0]  data_byte;
        logic        last_in_run;
        logic        pixel_changed;
        logic [10:0] dirty_total;
        logic        full_mode;
    } result_t;

endpackage

@@ hw/rtl/dirty_tracked_frame_refresh_top.sv @@
// Channel  | Signals                          | Handshake
// command  | start, busy, cmd                 | taken when start && !busy
// result   | result_valid, result             | one-cycle strobe, no backpressure
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// A draw steps through the executor as queue pop, memory read, execute, respond.
// A start, and any request answered as busy, skip the execute step; a data byte
// adds a frame read and a data capture before the response. A position pull in full
// mode answers from the seek read; partial mode scans dirty pages column by column.
// A clear sweeps both memories, a refresh end just the dirty one, one cell per cycle
// (FRAME_WIDTH*PAGE_COUNT cells); reset starts the same sweep before any command runs.
// Up to two commands queue ahead of the executor; busy rises when the queue is full.
// The receiver cannot stall; each result is presented for exactly one cycle.
module dirty_tracked_frame_refresh_top #(
    parameter int FRAME_WIDTH = dtfr_pkg::FRAME_WIDTH_DEF,
    parameter int PAGE_COUNT  = dtfr_pkg::PAGE_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dtfr_pkg::cmd_t       cmd,
    output logic                 result_valid,
    output dtfr_pkg::result_t    result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [10:0]          cfg_data
);

    logic            q_valid;
    dtfr_pkg::cmd_t  q_cmd;
    logic            q_pop;
    logic [10:0]     thresh_reg;
    logic [1:0]      offset_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= dtfr_pkg::THRESH_RESET;
            offset_reg <= dtfr_pkg::OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == dtfr_pkg::REG_THRESH)
                thresh_reg <= cfg_data;
            else
                offset_reg <= cfg_data[1:0];
        end
    end

    dtfr_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

    dtfr_back #(.FRAME_WIDTH(FRAME_WIDTH), .PAGE_COUNT(PAGE_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .thresh(thresh_reg), .col_off(offset_reg),
        .res_strobe(result_valid), .res(result));

endmodule

@@ hw/rtl/dtfr_ram.sv @@
module dtfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/dtfr_front.sv @@
// Accepts commands and queues them for the back end.
module dtfr_front #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dtfr_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            q_valid,
    output dtfr_pkg::cmd_t  q_cmd,
    input  logic            q_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dtfr_pkg::cmd_t  slot_reg [DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   rd_reg;
    logic [AW:0]     cnt_reg;
    logic            push;

    assign busy    = (cnt_reg == (AW+1)'(DEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = slot_reg[rd_reg];

    // Command queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= cmd;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> cnt_reg != '0) else $error("queue count lost");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count too high");

endmodule

@@ hw/rtl/dtfr_back.sv @@
// Executes commands against the frame and dirty memories.
module dtfr_back #(
    parameter int FRAME_WIDTH = 128,
    parameter int PAGE_COUNT  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  dtfr_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    input  logic [10:0]       thresh,
    input  logic [1:0]        col_off,
    output logic              res_strobe,
    output dtfr_pkg::result_t res
);

    localparam int CW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CELLS = FRAME_WIDTH * PAGE_COUNT;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EXEC, S_SEEK_RD, S_SEEK, S_DATA_RD, S_DATA,
        S_WIPE, S_RESP
    } state_t;

    typedef enum logic [1:0] { PH_IDLE, PH_SEEK, PH_DATA } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    dtfr_pkg::cmd_t    cmd_reg;
    logic [PW:0]       page_reg;
    logic [CW:0]       col_reg;
    logic [PAGE_COUNT-1:0] dpages_reg;
    logic [10:0]       count_reg;
    logic              force_reg;
    logic              full_reg;
    logic [AW:0]       wipe_reg;
    logic              wipe_dirty_reg;
    logic [2:0]        kind_reg;
    logic [2:0]        opage_reg;
    logic [7:0]        ocol_reg;
    logic [7:0]        obyte_reg;
    logic              olast_reg;
    logic              ochg_reg;
    logic              strobe_reg;

    // Memory ports.
    logic              f_we;
    logic [AW-1:0]     f_waddr;
    logic [7:0]        f_wdata;
    logic [AW-1:0]     f_raddr;
    logic [7:0]        f_rdata;
    logic              d_we;
    logic [AW-1:0]     d_waddr;
    logic              d_wdata;
    logic [AW-1:0]     d_raddr;
    logic              d_rdata;

    logic              in_frame;
    logic [AW-1:0]     draw_addr;
    logic [7:0]        bitmask;
    logic [AW-1:0]     scan_addr;
    logic [AW-1:0]     next_addr;
    logic              page_done;

    // A wipe answers a command unless it is the one that follows reset.
    function automatic logic strobe_pending(logic [1:0] m, logic from_done);
        strobe_pending = from_done || (m == dtfr_pkg::MODE_CLEAR);
    endfunction

    dtfr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_frame (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));

    dtfr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_dirty (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata));

    assign in_frame  = (32'(cmd_reg.pixel_x) < FRAME_WIDTH) &&
                       (32'(cmd_reg.pixel_y) < 8 * PAGE_COUNT);
    assign draw_addr = AW'(32'(cmd_reg.pixel_y >> 3) * FRAME_WIDTH + 32'(cmd_reg.pixel_x));
    assign bitmask   = 8'h01 << cmd_reg.pixel_y[2:0];
    assign scan_addr = AW'(32'(page_reg) * FRAME_WIDTH + 32'(col_reg));
    assign next_addr = scan_addr + 1'b1;
    assign page_done = (32'(col_reg) + 1 >= FRAME_WIDTH);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    // Memory addressing and write enables.
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = draw_addr;
        f_wdata = f_rdata ^ bitmask;
        f_raddr = draw_addr;
        d_we    = 1'b0;
        d_waddr = draw_addr;
        d_wdata = 1'b1;
        d_raddr = draw_addr;
        case (state_reg)
            S_EXEC:
            begin
                if (in_frame && (((f_rdata & bitmask) != 8'd0) != cmd_reg.pixel_on))
                begin
                    f_we = 1'b1;
                    d_we = !d_rdata;
                end
            end
            S_SEEK_RD, S_SEEK:
            begin
                d_raddr = (state_reg == S_SEEK) ? next_addr : scan_addr;
            end
            S_DATA_RD:
            begin
                f_raddr = scan_addr;
                d_raddr = next_addr;
            end
            S_WIPE:
            begin
                f_we    = !wipe_dirty_reg;
                f_waddr = wipe_reg[AW-1:0];
                f_wdata = 8'd0;
                d_we    = 1'b1;
                d_waddr = wipe_reg[AW-1:0];
                d_wdata = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Command sequencer and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WIPE;
            phase_reg      <= PH_IDLE;
            cmd_reg        <= '0;
            page_reg       <= '0;
            col_reg        <= '0;
            dpages_reg     <= '0;
            count_reg      <= '0;
            force_reg      <= 1'b1;
            full_reg       <= 1'b0;
            wipe_reg       <= '0;
            wipe_dirty_reg <= 1'b0;
            kind_reg       <= dtfr_pkg::KIND_ACK;
            opage_reg      <= '0;
            ocol_reg       <= '0;
            obyte_reg      <= '0;
            olast_reg      <= 1'b0;
            ochg_reg       <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        kind_reg  <= dtfr_pkg::KIND_ACK;
                        opage_reg <= '0;
                        ocol_reg  <= '0;
                        obyte_reg <= '0;
                        olast_reg <= 1'b0;
                        ochg_reg  <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RESP;
                    case (cmd_reg.mode)
                        dtfr_pkg::MODE_DRAW:
                        begin
                            if (phase_reg != PH_IDLE)
                                kind_reg <= dtfr_pkg::KIND_BUSY;
                            else
                                state_reg <= S_EXEC;
                        end
                        dtfr_pkg::MODE_START:
                        begin
                            if (phase_reg != PH_IDLE)
                                kind_reg <= dtfr_pkg::KIND_BUSY;
                            else
                            begin
                                full_reg  <= force_reg || (count_reg > thresh);
                                if (force_reg || (count_reg > thresh))
                                    force_reg <= 1'b0;
                                phase_reg <= PH_SEEK;
                                page_reg  <= '0;
                                col_reg   <= '0;
                            end
                        end
                        dtfr_pkg::MODE_PULL:
                        begin
                            if (phase_reg == PH_IDLE)
                                kind_reg <= dtfr_pkg::KIND_BUSY;
                            else if (phase_reg == PH_SEEK)
                                state_reg <= S_SEEK_RD;
                            else
                                state_reg <= S_DATA_RD;
                        end
                        default:
                        begin
                            if (phase_reg != PH_IDLE)
                                kind_reg <= dtfr_pkg::KIND_BUSY;
                            else
                            begin
                                force_reg      <= 1'b1;
                                wipe_dirty_reg <= 1'b0;
                                wipe_reg       <= '0;
                                state_reg      <= S_WIPE;
                            end
                        end
                    endcase
                end
                S_EXEC:
                begin
                    if (in_frame && (((f_rdata & bitmask) != 8'd0) != cmd_reg.pixel_on))
                    begin
                        ochg_reg <= 1'b1;
                        if (!d_rdata)
                        begin
                            dpages_reg[cmd_reg.pixel_y[PW+2:3]] <= 1'b1;
                            if (count_reg != dtfr_pkg::COUNT_LIMIT)
                                count_reg <= count_reg + 1'b1;
                        end
                    end
                    state_reg <= S_RESP;
                end
                S_SEEK_RD:
                begin
                    // For each column, issue the dirty read here and test it in S_SEEK.
                    if (32'(page_reg) >= PAGE_COUNT)
                    begin
                        kind_reg       <= dtfr_pkg::KIND_DONE;
                        phase_reg      <= PH_IDLE;
                        page_reg       <= '0;
                        col_reg        <= '0;
                        dpages_reg     <= '0;
                        count_reg      <= '0;
                        wipe_dirty_reg <= 1'b1;
                        wipe_reg       <= '0;
                        state_reg      <= S_WIPE;
                    end
                    else if (full_reg)
                    begin
                        kind_reg  <= dtfr_pkg::KIND_POS;
                        opage_reg <= 3'(page_reg);
                        ocol_reg  <= 8'(col_reg) + 8'(col_off);
                        phase_reg <= PH_DATA;
                        state_reg <= S_RESP;
                    end
                    else if (!dpages_reg[page_reg[PW-1:0]] || 32'(col_reg) >= FRAME_WIDTH)
                    begin
                        page_reg <= page_reg + 1'b1;
                        col_reg  <= '0;
                    end
                    else
                    begin
                        state_reg <= S_SEEK;
                    end
                end
                S_SEEK:
                begin
                    if (d_rdata)
                    begin
                        kind_reg  <= dtfr_pkg::KIND_POS;
                        opage_reg <= 3'(page_reg);
                        ocol_reg  <= 8'(col_reg) + 8'(col_off);
                        phase_reg <= PH_DATA;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_SEEK_RD;
                    end
                end
                S_DATA_RD:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    kind_reg  <= dtfr_pkg::KIND_DATA;
                    obyte_reg <= f_rdata;
                    state_reg <= S_RESP;
                    if (page_done || (!full_reg && !d_rdata))
                    begin
                        olast_reg <= 1'b1;
                        phase_reg <= PH_SEEK;
                        if (page_done)
                        begin
                            col_reg  <= '0;
                            page_reg <= page_reg + 1'b1;
                        end
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                    else
                        col_reg <= col_reg + 1'b1;
                end
                S_WIPE:
                begin
                    wipe_reg <= wipe_reg + 1'b1;
                    if (32'(wipe_reg) == CELLS - 1)
                    begin
                        dpages_reg <= '0;
                        count_reg  <= '0;
                        // The wipe after reset produces no result.
                        state_reg  <= strobe_pending(cmd_reg.mode, wipe_dirty_reg)
                                      ? S_RESP : S_IDLE;
                    end
                end
                S_RESP:
                begin
                    strobe_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_strobe        = strobe_reg;
    assign res.kind          = kind_reg;
    assign res.page          = opage_reg;
    assign res.ram_column    = ocol_reg;
    assign res.data_byte     = obyte_reg;
    assign res.last_in_run   = olast_reg;
    assign res.pixel_changed = ochg_reg;
    assign res.dirty_total   = count_reg;
    assign res.full_mode     = full_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |=> !res_strobe) else $error("double result");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_RD) else $error("pop without execution");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && res.kind == dtfr_pkg::KIND_DONE) |-> res.dirty_total == '0)
        else $error("done with dirty count");

endmodule
